@@ rtl/deficit_round_robin_scheduler_macros.svh @@
// assertion macros for the deficit round-robin scheduler
`ifndef DEFICIT_ROUND_ROBIN_SCHEDULER_MACROS_SVH
`define DEFICIT_ROUND_ROBIN_SCHEDULER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DRR_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define DRR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define DRR_ASSERT(label, clk, rst_n, prop)
`define DRR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/drr_pkg.sv @@
// types and constants for the deficit round-robin scheduler
`default_nettype none
package drr_pkg;
  localparam int unsigned QIDX_BITS = 3;
  localparam int unsigned PLEN_BITS = 16;
  localparam logic [15:0] QUANTUM_RESET = 16'd500;

  typedef enum logic [1:0] {
    ST_GRANT   = 2'd0,
    ST_NONE    = 2'd1,
    ST_ENQUEUE = 2'd2,
    ST_DROP    = 2'd3
  } status_t;

  localparam logic REQ_ENQUEUE = 1'b0;
  localparam logic REQ_PULL    = 1'b1;

  typedef struct packed {
    logic                 req_type;
    logic [QIDX_BITS-1:0] queue_index;
    logic [PLEN_BITS-1:0] packet_length;
  } drr_in_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [QIDX_BITS-1:0] grant_queue;
    logic [PLEN_BITS-1:0] grant_length;
    logic                 backlog;
  } drr_out_t;
endpackage
`default_nettype wire

@@ rtl/drr_ram.sv @@
// generic single-port-write ram with registered read
`default_nettype none
module drr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_addr] <= wr_data;
    rd_data <= mem_r[rd_addr];
  end
endmodule
`default_nettype wire

@@ rtl/drr_front.sv @@
// input skid queue between the handshake and the scheduling engine
`default_nettype none
`include "deficit_round_robin_scheduler_macros.svh"
module drr_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire drr_pkg::drr_in_t  in_data,
  output logic                   q_valid,
  input  wire logic              q_take,
  output drr_pkg::drr_in_t       q_data
);
  import drr_pkg::*;
  drr_in_t  slot_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic     wp_r, rp_r;
  logic     push, pop;

  assign in_stall = cnt_r[1];
  assign push = in_valid && !in_stall;
  assign q_valid = cnt_r != 2'd0;
  assign pop = q_take && q_valid;
  assign q_data = slot_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    else if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; wp_r <= 1'b0; rp_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
    end
    if (push) slot_r[wp_r] <= in_data;
  end

  `DRR_ASSERT(a_cnt_max, clk, rst_n, cnt_r <= 2'd2)
  `DRR_ASSERT_NEXT(a_full_hold, clk, rst_n, cnt_r == 2'd2 && !pop, cnt_r == 2'd2)
  `DRR_ASSERT(a_ptr_cnt, clk, rst_n, (cnt_r == 2'd1) == (wp_r != rp_r))
endmodule
`default_nettype wire

@@ rtl/drr_back.sv @@
// scheduling engine: per-queue fifos, deficits and the scan sequencer
`default_nettype none
`include "deficit_round_robin_scheduler_macros.svh"
module drr_back #(
  parameter int unsigned NUM_QUEUES  = 8,
  parameter int unsigned FIFO_DEPTH  = 16,
  parameter int unsigned LENGTH_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [15:0]       cfg_wr_data,
  input  wire logic              q_valid,
  output logic                   q_take,
  input  wire drr_pkg::drr_in_t  q_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output drr_pkg::drr_out_t      out_data
);
  import drr_pkg::*;
  localparam int unsigned QB = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int unsigned FB = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CB = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned WB = CB + 1;
  localparam int unsigned DB = LENGTH_BITS + 1;
  localparam int unsigned SB = ((DB > 16) ? DB : 16) + 1;
  localparam int unsigned AB = QB + FB;
  localparam logic [DB-1:0] DEF_MAX = '1;
  localparam logic [QB-1:0] LAST_Q = QB'(NUM_QUEUES - 1);
  localparam logic [FB-1:0] LAST_P = FB'(FIFO_DEPTH - 1);
  localparam logic [CB-1:0] DEPTH_C = CB'(FIFO_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_EVAL  = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t          state_r, state_nxt;
  logic [15:0]     quantum_r;
  logic [CB-1:0]   cnt_r  [NUM_QUEUES];
  logic [FB-1:0]   rdp_r  [NUM_QUEUES];
  logic [DB-1:0]   def_r  [NUM_QUEUES];
  logic [QB-1:0]   scan_r;
  logic [QB:0]     visit_r;
  logic            bl_r;
  drr_out_t        res_r;
  logic [QB-1:0]   nq;
  logic [SB-1:0]   sum;
  logic [DB-1:0]   credited;
  logic            ram_we;
  logic [AB-1:0]   ram_wa, ram_ra;
  logic [LENGTH_BITS-1:0] ram_rd, wr_len;
  logic [FB-1:0]   wr_ptr;
  logic [WB-1:0]   wsum;
  logic [QB-1:0]   qi;
  logic            enq_ok;
  logic            out_free;
  logic            grant_hit;
  logic            last_visit;

  assign out_free = !out_valid || !out_stall;
  assign out_data = res_r;
  assign q_take = (state_r == S_IDLE) && out_free;
  assign nq = (scan_r == LAST_Q) ? '0 : scan_r + QB'(1);
  assign sum = SB'(def_r[nq]) + SB'(quantum_r);
  assign credited = (sum > SB'(DEF_MAX)) ? DEF_MAX : sum[DB-1:0];
  assign grant_hit = cnt_r[scan_r] != '0 && {1'b0, ram_rd} <= def_r[scan_r];
  assign last_visit = visit_r == (QB+1)'(NUM_QUEUES - 1);

  assign qi = QB'(q_data.queue_index);
  assign enq_ok = q_data.req_type == REQ_ENQUEUE &&
                  {{(32-QIDX_BITS){1'b0}}, q_data.queue_index} < NUM_QUEUES &&
                  cnt_r[qi] < DEPTH_C;
  assign wsum = WB'(rdp_r[qi]) + WB'(cnt_r[qi]);
  assign wr_ptr = FB'((wsum >= WB'(FIFO_DEPTH)) ? wsum - WB'(FIFO_DEPTH) : wsum);
  assign wr_len = LENGTH_BITS'(q_data.packet_length);
  assign ram_we = q_take && q_valid && enq_ok;
  assign ram_wa = AB'({qi, wr_ptr});
  assign ram_ra = AB'({scan_r, rdp_r[scan_r]});

  drr_ram #(.WIDTH(LENGTH_BITS), .DEPTH(2**AB)) u_ram (
    .clk(clk), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(wr_len),
    .rd_addr(ram_ra), .rd_data(ram_rd)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (q_valid && out_free)
                state_nxt = (q_data.req_type == REQ_PULL) ? S_READ : S_OUT;
      S_READ: state_nxt = S_EVAL;
      S_EVAL: state_nxt = (grant_hit || last_visit) ? S_OUT : S_READ;
      S_OUT:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      quantum_r <= QUANTUM_RESET;
      scan_r <= '0;
      visit_r <= '0;
      bl_r <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        cnt_r[i] <= '0; rdp_r[i] <= '0; def_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en && cfg_wr_data != 16'd0) quantum_r <= cfg_wr_data;
      out_valid <= (state_r == S_OUT) || (out_valid && out_stall);
      if (state_r == S_IDLE && q_valid && out_free) begin
        visit_r <= '0;
        bl_r <= 1'b0;
        if (q_data.req_type == REQ_ENQUEUE) begin
          res_r <= {enq_ok ? ST_ENQUEUE : ST_DROP, {QIDX_BITS{1'b0}},
                    {PLEN_BITS{1'b0}}, 1'b0};
          if (enq_ok) cnt_r[qi] <= cnt_r[qi] + CB'(1);
        end
      end
      if (state_r == S_EVAL) begin
        if (grant_hit) begin
          def_r[scan_r] <= def_r[scan_r] - {1'b0, ram_rd};
          rdp_r[scan_r] <= (rdp_r[scan_r] == LAST_P) ? '0 : rdp_r[scan_r] + FB'(1);
          cnt_r[scan_r] <= cnt_r[scan_r] - CB'(1);
          res_r <= {ST_GRANT, QIDX_BITS'(scan_r), PLEN_BITS'(ram_rd), 1'b1};
        end else begin
          if (cnt_r[scan_r] == '0) begin
            if (nq != scan_r) def_r[scan_r] <= '0;
          end else bl_r <= 1'b1;
          scan_r <= nq;
          def_r[nq] <= credited;
          visit_r <= visit_r + (QB+1)'(1);
          if (last_visit) begin
            res_r <= {ST_NONE, {QIDX_BITS{1'b0}}, {PLEN_BITS{1'b0}},
                      bl_r || cnt_r[scan_r] != '0};
          end
        end
      end
    end
  end

  `DRR_ASSERT(a_visit_bound, clk, rst_n, visit_r <= (QB+1)'(NUM_QUEUES))
  `DRR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `DRR_ASSERT(a_take_idle, clk, rst_n, !q_take || state_r == S_IDLE)
endmodule
`default_nettype wire

@@ rtl/deficit_round_robin_scheduler.sv @@
// top level of the deficit round-robin scheduler
// usage:
// in channel: in_valid/in_stall with in_data; enqueue or pull transaction.
// out channel: out_valid/out_stall with out_data; one result per transaction.
// cfg port: cfg_wr_en/cfg_wr_data writes the quantum; zero is ignored.
// a two-entry input queue feeds a sequential engine that works on one
// transaction at a time.
// enqueue: after acceptance the engine goes through S_OUT, and out_valid is then registered.
// pull: each queue visited takes a fifo ram read, then a deficit update; at most
// NUM_QUEUES queues are visited, and an early grant ends the scan sooner.
// the per-queue length ram has a registered read port, which is why a visit
// needs separate read and evaluate states.
// reset clears counts, pointers, deficits and sets quantum to 500;
// ram contents are left as they are.
// while out_stall holds, the result register keeps its value and the
// engine waits; the input queue still takes up to two transactions.
`default_nettype none
module deficit_round_robin_scheduler #(
  parameter int unsigned NUM_QUEUES  = 8,
  parameter int unsigned FIFO_DEPTH  = 16,
  parameter int unsigned LENGTH_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [15:0]       cfg_wr_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire drr_pkg::drr_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output drr_pkg::drr_out_t      out_data
);
  import drr_pkg::*;
  logic    q_valid, q_take;
  drr_in_t q_data;

  drr_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .q_valid(q_valid), .q_take(q_take), .q_data(q_data)
  );

  drr_back #(.NUM_QUEUES(NUM_QUEUES), .FIFO_DEPTH(FIFO_DEPTH),
             .LENGTH_BITS(LENGTH_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .q_valid(q_valid), .q_take(q_take), .q_data(q_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );
endmodule
`default_nettype wire
